[rtl/core/riscv_call_return_tracer_defines.svh]
// assertion macros used by the tracer top module
`ifndef RISCV_CALL_RETURN_TRACER_DEFINES_SVH
`define RISCV_CALL_RETURN_TRACER_DEFINES_SVH

// same-cycle implication
`define RCRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcrt assertion failed");

// next-cycle implication
`define RCRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcrt assertion failed");

`endif

[rtl/core/rcrt_pkg.sv]
// shared types, constants and decode helpers of the call/return tracer
package rcrt_pkg;

    localparam int MAX_SYMBOLS_DEF = 64;
    localparam int DEPTH_MAX_DEF   = 1023;

    localparam int XLEN      = 32;
    localparam int COUNT_W   = 7;
    localparam int INDEX_W   = 6;
    localparam int DEPTH_O_W = 10;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_TRACE = 1'b1;
    localparam logic       EVT_CALL = 1'b0;
    localparam logic       EVT_RET  = 1'b1;

    localparam logic [6:0] OPC_JAL  = 7'h6f;
    localparam logic [6:0] OPC_JALR = 7'h67;
    localparam logic [2:0] F3_JALR  = 3'b000;
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_T0   = 5'd5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_CALL,
        CMD_RET
    } t_cmd_op;

    // a holds start or pc, b holds size or next pc
    typedef struct packed {
        t_cmd_op            op;
        logic [INDEX_W-1:0] index;
        logic [XLEN-1:0]    a;
        logic [XLEN-1:0]    b;
        logic [XLEN-1:0]    addr;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

    typedef struct packed {
        logic scanning;
        logic entry_wr;
    } t_back_stat;

    function automatic logic [XLEN-1:0] jal_offset(input logic [XLEN-1:0] w);
        jal_offset = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    endfunction

endpackage

[rtl/core/rcrt_front.sv]
// front end: accepts beats, decodes calls and returns, feeds the command queue
module rcrt_front (
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [rcrt_pkg::INDEX_W-1:0]    i_entry_index,
    input  logic [rcrt_pkg::XLEN-1:0]       i_entry_start,
    input  logic [rcrt_pkg::XLEN-1:0]       i_entry_size,
    input  logic [rcrt_pkg::XLEN-1:0]       i_pc,
    input  logic [rcrt_pkg::XLEN-1:0]       i_instruction,
    input  logic [rcrt_pkg::XLEN-1:0]       i_next_pc,
    input  logic [rcrt_pkg::COUNT_W-1:0]    i_symbol_count,
    input  logic                            i_q_full,
    output logic                            o_push,
    output rcrt_pkg::t_cmd                  o_cmd
);

    logic       accept;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic       is_jal;
    logic       is_jalr;
    logic       link_rd;
    logic       is_event;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    assign rd      = i_instruction[11:7];
    assign rs1     = i_instruction[19:15];
    assign is_jal  = i_instruction[6:0] == rcrt_pkg::OPC_JAL;
    assign is_jalr = (i_instruction[6:0] == rcrt_pkg::OPC_JALR) &&
                     (i_instruction[14:12] == rcrt_pkg::F3_JALR);
    assign link_rd = (rd == rcrt_pkg::REG_RA) || (rd == rcrt_pkg::REG_T0);

    always_comb begin
        is_event   = 1'b0;
        o_cmd.op   = rcrt_pkg::CMD_WRITE;
        o_cmd.addr = i_next_pc;
        if (i_operation == rcrt_pkg::OP_WRITE) begin
            o_cmd.op = rcrt_pkg::CMD_WRITE;
        end else if (is_jal && link_rd) begin
            is_event   = 1'b1;
            o_cmd.op   = rcrt_pkg::CMD_CALL;
            o_cmd.addr = i_pc + rcrt_pkg::jal_offset(i_instruction);
        end else if (is_jalr && rd == rcrt_pkg::REG_ZERO && rs1 == rcrt_pkg::REG_RA) begin
            is_event = 1'b1;
            o_cmd.op = rcrt_pkg::CMD_RET;
        end else if (is_jalr && link_rd) begin
            is_event = 1'b1;
            o_cmd.op = rcrt_pkg::CMD_CALL;
        end
        o_cmd.index = i_entry_index;
        o_cmd.a     = (i_operation == rcrt_pkg::OP_WRITE) ? i_entry_start : i_pc;
        o_cmd.b     = (i_operation == rcrt_pkg::OP_WRITE) ? i_entry_size  : i_next_pc;
    end

    // tracing is off while no symbols are loaded; such beats are dropped here
    assign o_push = accept && ((i_operation == rcrt_pkg::OP_WRITE) ||
                               (is_event && (i_symbol_count != '0)));

endmodule

[rtl/core/rcrt_queue.sv]
// short command queue between the decode front end and the lookup back end
module rcrt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rcrt_pkg::t_cmd  i_data,
    output logic            o_full,
    output logic            o_valid,
    output rcrt_pkg::t_cmd  o_data,
    input  logic            i_pop
);

    rcrt_pkg::t_cmd                     r_slot [rcrt_pkg::QUEUE_DEPTH];
    logic [rcrt_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [rcrt_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [rcrt_pkg::QCNT_W-1:0]        r_count;

    assign o_full  = r_count == rcrt_pkg::QCNT_W'(rcrt_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/core/rcrt_back.sv]
// back end: symbol table memory, nesting depth, table scan and result register
module rcrt_back #(
    parameter int MAX_SYMBOLS = rcrt_pkg::MAX_SYMBOLS_DEF,
    parameter int DEPTH_MAX   = rcrt_pkg::DEPTH_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [rcrt_pkg::COUNT_W-1:0]    i_symbol_count,
    input  logic                            i_q_valid,
    input  rcrt_pkg::t_cmd                  i_cmd,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_event_kind,
    output logic [rcrt_pkg::XLEN-1:0]       o_event_pc,
    output logic [rcrt_pkg::XLEN-1:0]       o_event_target,
    output logic [rcrt_pkg::DEPTH_O_W-1:0]  o_nesting_depth,
    output logic                            o_symbol_found,
    output logic [rcrt_pkg::INDEX_W-1:0]    o_symbol_index,
    output rcrt_pkg::t_back_stat            o_stat
);

    localparam int IDX_W   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int LIM_W   = (CNT_W > rcrt_pkg::COUNT_W) ? CNT_W : rcrt_pkg::COUNT_W;
    localparam int SLOT_W  = (CNT_W > rcrt_pkg::INDEX_W) ? CNT_W : rcrt_pkg::INDEX_W;
    localparam int DEPTH_W = $clog2(DEPTH_MAX + 1);
    localparam int DOUT_W  = (DEPTH_W > rcrt_pkg::DEPTH_O_W) ? DEPTH_W : rcrt_pkg::DEPTH_O_W;

    logic [rcrt_pkg::XLEN-1:0]  mem_start [MAX_SYMBOLS];
    logic [rcrt_pkg::XLEN-1:0]  mem_size  [MAX_SYMBOLS];

    rcrt_pkg::t_back_state      r_state;
    rcrt_pkg::t_back_state      n_state;
    logic [DEPTH_W-1:0]         r_depth;
    logic [CNT_W-1:0]           r_limit;
    logic [CNT_W-1:0]           r_issue;
    logic                       r_cmp_vld;
    logic [CNT_W-1:0]           r_cmp_idx;
    logic [rcrt_pkg::XLEN-1:0]  r_rd_start;
    logic [rcrt_pkg::XLEN-1:0]  r_rd_size;
    logic [rcrt_pkg::XLEN-1:0]  r_addr;
    logic                       r_kind;
    logic [rcrt_pkg::XLEN-1:0]  r_pc;
    logic [rcrt_pkg::XLEN-1:0]  r_target;
    logic [DEPTH_W-1:0]         r_ev_depth;
    logic                       r_out_valid;
    logic                       r_out_kind;
    logic [rcrt_pkg::XLEN-1:0]  r_out_pc;
    logic [rcrt_pkg::XLEN-1:0]  r_out_target;
    logic [DEPTH_W-1:0]         r_out_depth;
    logic                       r_out_found;
    logic [rcrt_pkg::INDEX_W-1:0] r_out_index;

    logic                       pop_write;
    logic                       pop_trace;
    logic [SLOT_W-1:0]          wr_idx_ext;
    logic                       wr_ok;
    logic [IDX_W-1:0]           wr_addr;
    logic [IDX_W-1:0]           rd_addr;
    logic [LIM_W-1:0]           count_ext;
    logic [CNT_W-1:0]           limit;
    logic [rcrt_pkg::XLEN-1:0]  span;
    logic [rcrt_pkg::XLEN-1:0]  offset;
    logic                       in_range;
    logic                       scan_hit;
    logic                       scan_last;
    logic                       scan_done;
    logic [SLOT_W-1:0]          hit_idx_ext;
    logic [DOUT_W-1:0]          depth_ext;

    assign pop_write = o_pop && (i_cmd.op == rcrt_pkg::CMD_WRITE);
    assign pop_trace = o_pop && (i_cmd.op != rcrt_pkg::CMD_WRITE);

    assign wr_idx_ext = SLOT_W'(i_cmd.index);
    assign wr_ok      = wr_idx_ext < SLOT_W'(MAX_SYMBOLS);
    assign wr_addr    = wr_idx_ext[IDX_W-1:0];
    assign rd_addr    = r_issue[IDX_W-1:0];

    // counts beyond the table size act as the table size
    assign count_ext = LIM_W'(i_symbol_count);
    assign limit     = (count_ext > LIM_W'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS)
                                                         : count_ext[CNT_W-1:0];

    // start <= addr < start + len without wrap, len of zero taken as four
    assign span      = (r_rd_size == '0) ? rcrt_pkg::XLEN'(4) : r_rd_size;
    assign offset    = r_addr - r_rd_start;
    assign in_range  = (r_addr >= r_rd_start) && (offset < span);
    assign scan_hit  = r_cmp_vld && in_range;
    assign scan_last = r_cmp_vld && (r_cmp_idx == r_limit - 1'b1);
    assign scan_done = (r_state == rcrt_pkg::BK_SCAN) && (scan_hit || scan_last);

    assign hit_idx_ext = SLOT_W'(r_cmp_idx);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcrt_pkg::BK_IDLE: begin
                if (pop_trace) begin
                    n_state = rcrt_pkg::BK_SCAN;
                end
            end
            rcrt_pkg::BK_SCAN: begin
                if (scan_done) begin
                    n_state = rcrt_pkg::BK_IDLE;
                end
            end
            default: n_state = rcrt_pkg::BK_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_pop           = 1'b0;
        o_stat.scanning = 1'b0;
        unique case (r_state)
            rcrt_pkg::BK_IDLE: begin
                // a lookup starts only when the result register will be free
                o_pop = i_q_valid && ((i_cmd.op == rcrt_pkg::CMD_WRITE) ||
                                      !r_out_valid || !i_stall);
            end
            rcrt_pkg::BK_SCAN: begin
                o_stat.scanning = 1'b1;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
        o_stat.entry_wr = pop_write && wr_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcrt_pkg::BK_IDLE;
            r_depth     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == rcrt_pkg::BK_SCAN) && !scan_done && (r_issue < r_limit);
            if (pop_write && wr_ok) begin
                r_depth <= '0;
            end else if (pop_trace && i_cmd.op == rcrt_pkg::CMD_CALL) begin
                if (r_depth < DEPTH_W'(DEPTH_MAX)) begin
                    r_depth <= r_depth + 1'b1;
                end
            end else if (pop_trace && i_cmd.op == rcrt_pkg::CMD_RET) begin
                if (r_depth != '0) begin
                    r_depth <= r_depth - 1'b1;
                end
            end
            if (scan_done) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_trace) begin
            r_issue  <= '0;
            r_limit  <= limit;
            r_addr   <= i_cmd.addr;
            r_pc     <= i_cmd.a;
            r_target <= i_cmd.b;
            if (i_cmd.op == rcrt_pkg::CMD_RET) begin
                r_kind     <= rcrt_pkg::EVT_RET;
                r_ev_depth <= (r_depth != '0) ? r_depth - 1'b1 : r_depth;
            end else begin
                r_kind     <= rcrt_pkg::EVT_CALL;
                r_ev_depth <= r_depth;
            end
        end else if (r_state == rcrt_pkg::BK_SCAN) begin
            r_issue <= r_issue + 1'b1;
        end
        r_cmp_idx <= r_issue;
        if (scan_done) begin
            r_out_kind   <= r_kind;
            r_out_pc     <= r_pc;
            r_out_target <= r_target;
            r_out_depth  <= r_ev_depth;
            r_out_found  <= scan_hit;
            r_out_index  <= scan_hit ? hit_idx_ext[rcrt_pkg::INDEX_W-1:0] : '0;
        end
    end

    // symbol table, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (pop_write && wr_ok) begin
            mem_start[wr_addr] <= i_cmd.a;
            mem_size[wr_addr]  <= i_cmd.b;
        end
        r_rd_start <= mem_start[rd_addr];
        r_rd_size  <= mem_size[rd_addr];
    end

    assign depth_ext       = DOUT_W'(r_out_depth);
    assign o_valid         = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_event_pc      = r_out_pc;
    assign o_event_target  = r_out_target;
    assign o_nesting_depth = depth_ext[rcrt_pkg::DEPTH_O_W-1:0];
    assign o_symbol_found  = r_out_found;
    assign o_symbol_index  = r_out_index;

endmodule

[rtl/core/riscv_call_return_tracer.sv]
// Function call/return tracer for retired RV32 instructions. Input beats either
// write a symbol table slot (start, size) or present one retired instruction;
// JAL/JALR with rd x1 or x5 is reported as a call and JALR with rd x0 and rs1 x1
// as a return, with the nesting depth and the first table entry covering the
// target. The input side takes one beat per cycle while its two-entry command
// queue has room; instructions other than calls and returns, and trace beats
// seen while the symbol count is zero, are dropped at the front and cost nothing
// further. For a call or return the back end scans table entries, one per
// cycle, up to the first hit or min(symbol_count, MAX_SYMBOLS) entries on a
// miss, and takes no command meanwhile. symbol_count is written through
// i_cfg_we/i_cfg_wdata by the user only while idle; not enforced by the block.
`include "riscv_call_return_tracer_defines.svh"

module riscv_call_return_tracer #(
    parameter int MAX_SYMBOLS = rcrt_pkg::MAX_SYMBOLS_DEF,
    parameter int DEPTH_MAX   = rcrt_pkg::DEPTH_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rcrt_pkg::COUNT_W-1:0]    i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [rcrt_pkg::INDEX_W-1:0]    i_entry_index,
    input  logic [rcrt_pkg::XLEN-1:0]       i_entry_start,
    input  logic [rcrt_pkg::XLEN-1:0]       i_entry_size,
    input  logic [rcrt_pkg::XLEN-1:0]       i_pc,
    input  logic [rcrt_pkg::XLEN-1:0]       i_instruction,
    input  logic [rcrt_pkg::XLEN-1:0]       i_next_pc,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_event_kind,
    output logic [rcrt_pkg::XLEN-1:0]       o_event_pc,
    output logic [rcrt_pkg::XLEN-1:0]       o_event_target,
    output logic [rcrt_pkg::DEPTH_O_W-1:0]  o_nesting_depth,
    output logic                            o_symbol_found,
    output logic [rcrt_pkg::INDEX_W-1:0]    o_symbol_index
);

    logic [rcrt_pkg::COUNT_W-1:0]   r_symbol_count;
    logic                           q_push;
    logic                           q_full;
    logic                           q_valid;
    logic                           q_pop;
    logic                           q_pop_trace;
    rcrt_pkg::t_cmd                 push_cmd;
    rcrt_pkg::t_cmd                 q_cmd;
    rcrt_pkg::t_back_stat           bk_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= '0;
        end else if (i_cfg_we) begin
            r_symbol_count <= i_cfg_wdata;
        end
    end

    rcrt_front u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_entry_index  (i_entry_index),
        .i_entry_start  (i_entry_start),
        .i_entry_size   (i_entry_size),
        .i_pc           (i_pc),
        .i_instruction  (i_instruction),
        .i_next_pc      (i_next_pc),
        .i_symbol_count (r_symbol_count),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (push_cmd)
    );

    rcrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    rcrt_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .DEPTH_MAX   (DEPTH_MAX)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_symbol_count  (r_symbol_count),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_event_pc      (o_event_pc),
        .o_event_target  (o_event_target),
        .o_nesting_depth (o_nesting_depth),
        .o_symbol_found  (o_symbol_found),
        .o_symbol_index  (o_symbol_index),
        .o_stat          (bk_stat)
    );

    assign q_pop_trace = q_pop && (q_cmd.op != rcrt_pkg::CMD_WRITE);

    `RCRT_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, q_push, !q_full)
    `RCRT_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, q_pop, q_valid)
    `RCRT_ASSERT_NEXT(a_trace_scans, i_clk, i_rst_n, q_pop_trace, bk_stat.scanning)
    `RCRT_ASSERT_NOW(a_result_after_scan, i_clk, i_rst_n, $rose(o_valid), $past(bk_stat.scanning))
    `RCRT_ASSERT_NOW(a_table_write_popped, i_clk, i_rst_n, bk_stat.entry_wr, q_pop && !bk_stat.scanning)

endmodule

[sim/tb_riscv_call_return_tracer.sv]
// self-checking testbench for the call/return tracer with its own event predictor
module tb_riscv_call_return_tracer;
    timeunit 1ns;
    timeprecision 1ps;

    import rcrt_pkg::*;

    localparam int          SETTLE_CYCLES = 100;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          N_PHASES      = 10;
    localparam int          CHAIN_CALLS   = 100;
    localparam logic [31:0] NOP_WORD      = 32'h0000_0013;
    localparam logic [2:0]  F3_NONZERO    = 3'b001;
    localparam logic [4:0]  REG_SP        = 5'd2;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] index;
        logic [XLEN-1:0]    start;
        logic [XLEN-1:0]    size;
        logic [XLEN-1:0]    pc;
        logic [XLEN-1:0]    instr;
        logic [XLEN-1:0]    npc;
    } trace_beat_t;

    typedef struct packed {
        logic                 kind;
        logic [XLEN-1:0]      pc;
        logic [XLEN-1:0]      target;
        logic [DEPTH_O_W-1:0] depth;
        logic                 found;
        logic [INDEX_W-1:0]   index;
    } trace_event_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [COUNT_W-1:0]   i_cfg_wdata = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic                 i_operation = 1'b0;
    logic [INDEX_W-1:0]   i_entry_index = '0;
    logic [XLEN-1:0]      i_entry_start = '0;
    logic [XLEN-1:0]      i_entry_size = '0;
    logic [XLEN-1:0]      i_pc = '0;
    logic [XLEN-1:0]      i_instruction = '0;
    logic [XLEN-1:0]      i_next_pc = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic                 o_event_kind;
    logic [XLEN-1:0]      o_event_pc;
    logic [XLEN-1:0]      o_event_target;
    logic [DEPTH_O_W-1:0] o_nesting_depth;
    logic                 o_symbol_found;
    logic [INDEX_W-1:0]   o_symbol_index;

    riscv_call_return_tracer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_entry_index   (i_entry_index),
        .i_entry_start   (i_entry_start),
        .i_entry_size    (i_entry_size),
        .i_pc            (i_pc),
        .i_instruction   (i_instruction),
        .i_next_pc       (i_next_pc),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_event_pc      (o_event_pc),
        .o_event_target  (o_event_target),
        .o_nesting_depth (o_nesting_depth),
        .o_symbol_found  (o_symbol_found),
        .o_symbol_index  (o_symbol_index)
    );

    // beats waiting to be driven and events waiting to come out
    trace_beat_t  trace_beats[$];
    trace_event_t expected_events[$];

    // predictor state
    logic [XLEN-1:0]    tbl_start[MAX_SYMBOLS_DEF];
    logic [XLEN-1:0]    tbl_size[MAX_SYMBOLS_DEF];
    int unsigned        pred_depth = 0;
    logic [COUNT_W-1:0] trace_count = '0;

    // stimulus-side view of the table, used only to aim targets
    logic [XLEN-1:0] gen_start[MAX_SYMBOLS_DEF];
    logic [XLEN-1:0] gen_size[MAX_SYMBOLS_DEF];
    logic [XLEN-1:0] win_base = '0;
    logic [XLEN-1:0] win_span = '0;
    int unsigned     live_slots = 0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;
    bit          in_taken = 1'b0;

    int unsigned beats_queued = 0;
    int unsigned beats_taken = 0;
    int unsigned n_events = 0;
    int unsigned n_calls = 0;
    int unsigned n_rets = 0;
    int unsigned n_hits = 0;
    int unsigned peak_depth = 0;
    int unsigned held_off = 0;
    int unsigned cfg_writes = 0;
    int unsigned errors = 0;
    int unsigned quiet = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // expected event of one accepted beat; updates the predictor state
    function automatic bit predict_event(input trace_beat_t b, output trace_event_t ev);
        logic [4:0]      rd;
        logic [4:0]      rs1;
        logic            is_jal;
        logic            is_jalr;
        logic [XLEN-1:0] addr;
        logic [XLEN-1:0] offs;
        logic [XLEN:0]   lo;
        logic [XLEN:0]   len;
        int unsigned     lim;
        ev = '0;
        if (b.op == OP_WRITE) begin
            tbl_start[b.index] = b.start;
            tbl_size[b.index] = b.size;
            pred_depth = 0;
            return 1'b0;
        end
        if (trace_count == 0)
            return 1'b0;
        rd = b.instr[11:7];
        rs1 = b.instr[19:15];
        is_jal = b.instr[6:0] == OPC_JAL;
        is_jalr = b.instr[6:0] == OPC_JALR && b.instr[14:12] == F3_JALR;
        offs = {{12{b.instr[31]}}, b.instr[19:12], b.instr[20], b.instr[30:21], 1'b0};
        ev.pc = b.pc;
        ev.target = b.npc;
        if (is_jal && (rd == REG_RA || rd == REG_T0)) begin
            ev.kind = EVT_CALL;
            addr = b.pc + offs;
            ev.depth = pred_depth[DEPTH_O_W-1:0];
            if (pred_depth < DEPTH_MAX_DEF)
                pred_depth++;
        end else if (is_jalr && rd == REG_ZERO && rs1 == REG_RA) begin
            ev.kind = EVT_RET;
            addr = b.npc;
            if (pred_depth > 0)
                pred_depth--;
            ev.depth = pred_depth[DEPTH_O_W-1:0];
        end else if (is_jalr && (rd == REG_RA || rd == REG_T0)) begin
            ev.kind = EVT_CALL;
            addr = b.npc;
            ev.depth = pred_depth[DEPTH_O_W-1:0];
            if (pred_depth < DEPTH_MAX_DEF)
                pred_depth++;
        end else begin
            return 1'b0;
        end
        // counts past the table size act as the table size
        lim = (trace_count > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : trace_count;
        for (int i = 0; i < lim; i++) begin
            lo = {1'b0, tbl_start[i]};
            len = (tbl_size[i] == 0) ? 33'd4 : {1'b0, tbl_size[i]};
            if ({1'b0, addr} >= lo && {1'b0, addr} < lo + len) begin
                ev.found = 1'b1;
                ev.index = INDEX_W'(i);
                return 1'b1;
            end
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [XLEN-1:0] exp_v,
                               input logic [XLEN-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // input beats
    always @(negedge i_clk) begin : drive_beats
        trace_beat_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (trace_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = trace_beats.pop_front();
                i_valid <= 1'b1;
                i_operation <= nxt.op;
                i_entry_index <= nxt.index;
                i_entry_start <= nxt.start;
                i_entry_size <= nxt.size;
                i_pc <= nxt.pc;
                i_instruction <= nxt.instr;
                i_next_pc <= nxt.npc;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with a long hold-off when one is requested
    always @(negedge i_clk) begin : drive_stall
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch_ports
        trace_beat_t  seen;
        trace_event_t ev;
        trace_event_t got;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = i_valid && !o_stall;
            if (i_valid && o_stall)
                held_off++;
            if (in_taken) begin
                beats_taken++;
                seen = '{i_operation, i_entry_index, i_entry_start, i_entry_size,
                         i_pc, i_instruction, i_next_pc};
                if (predict_event(seen, ev))
                    expected_events.push_back(ev);
            end
            if (o_valid && !i_stall) begin
                got = '{o_event_kind, o_event_pc, o_event_target, o_nesting_depth,
                        o_symbol_found, o_symbol_index};
                if (expected_events.size() == 0) begin
                    $error("event with none expected: pc %0h target %0h",
                           got.pc, got.target);
                    errors++;
                end else begin
                    ev = expected_events.pop_front();
                    check_field("event_kind", XLEN'(ev.kind), XLEN'(got.kind));
                    check_field("event_pc", ev.pc, got.pc);
                    check_field("event_target", ev.target, got.target);
                    check_field("nesting_depth", XLEN'(ev.depth), XLEN'(got.depth));
                    check_field("symbol_found", XLEN'(ev.found), XLEN'(got.found));
                    check_field("symbol_index", XLEN'(ev.index), XLEN'(got.index));
                end
                n_events++;
                if (got.kind == EVT_CALL)
                    n_calls++;
                else
                    n_rets++;
                if (got.found)
                    n_hits++;
                if (got.depth > peak_depth)
                    peak_depth = got.depth;
            end
            if (i_cfg_we)
                trace_count = i_cfg_wdata;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [31:0] jal_word(input logic [4:0] rd, input logic [31:0] off);
        jal_word = {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
    endfunction

    function automatic logic [31:0] jalr_word(input logic [4:0] rd, input logic [4:0] rs1,
                                              input logic [2:0] f3, input logic [11:0] imm);
        jalr_word = {imm, rs1, f3, rd, OPC_JALR};
    endfunction

    task automatic push_write(input logic [5:0] idx, input logic [31:0] st,
                              input logic [31:0] sz);
        trace_beat_t b;
        b = '{OP_WRITE, idx, st, sz, $urandom, $urandom, $urandom};
        gen_start[idx] = st;
        gen_size[idx] = sz;
        trace_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic push_trace(input logic [31:0] pc, input logic [31:0] word,
                              input logic [31:0] npc);
        trace_beat_t b;
        b = '{OP_TRACE, INDEX_W'($urandom), $urandom, $urandom, pc, word, npc};
        trace_beats.push_back(b);
        beats_queued++;
    endtask

    function automatic logic [31:0] pick_target();
        int unsigned r;
        int unsigned j;
        logic [31:0] len;
        r = $urandom_range(0, 99);
        if (r < 65)
            return win_base + $urandom_range(0, win_span + 32'h100);
        if (r < 80 && live_slots != 0) begin
            // boundaries of a live entry
            j = $urandom_range(0, live_slots - 1);
            len = (gen_size[j] == 0) ? 32'd4 : gen_size[j];
            case ($urandom_range(0, 2))
                0: return gen_start[j];
                1: return gen_start[j] + len - 1;
                default: return gen_start[j] + len;
            endcase
        end
        if (r < 90)
            return 32'hFFFF_FF00 + $urandom_range(0, 255);
        return $urandom;
    endfunction

    // fresh symbols in slots 0..k-1, mostly packed into one window
    task automatic load_symbols(input int unsigned k);
        logic [31:0] st;
        logic [31:0] sz;
        int unsigned r;
        case ($urandom_range(0, 3))
            0: win_base = 32'h0000_0000;
            1: win_base = 32'hFFF0_0000;
            default: win_base = $urandom & 32'hFFFF_F000;
        endcase
        win_span = k * 32'h400;
        live_slots = k;
        for (int i = 0; i < k; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                st = win_base + i * 32'h400 + ($urandom_range(0, 63) << 2);
                sz = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 32'h400);
            end else if (r < 88) begin
                // overlapping ranges, first slot wins
                st = win_base + $urandom_range(0, win_span);
                sz = $urandom_range(0, 32'h1000);
            end else if (r < 94) begin
                st = 32'hFFFF_FF00 + $urandom_range(0, 255);
                sz = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(0, 32'h200);
            end else begin
                st = $urandom;
                sz = $urandom;
            end
            push_write(6'(i), st, sz);
        end
    endtask

    task automatic push_random_beat();
        int unsigned r;
        logic [31:0] rnd;
        logic [31:0] off;
        logic [31:0] tgt;
        logic [4:0]  rd;
        r = $urandom_range(0, 99);
        rnd = $urandom;
        off = {{11{rnd[20]}}, rnd[20:1], 1'b0};
        tgt = pick_target();
        rd = $urandom_range(0, 1) ? REG_RA : REG_T0;
        if (r < 4) begin
            // table rewrite in the middle of a trace, clears the depth
            push_write(6'($urandom_range(0, 63)),
                       $urandom_range(0, 1) ? tgt : $urandom,
                       $urandom_range(0, 1) ? $urandom_range(0, 32'h400) : $urandom);
        end else if (r < 34) begin
            push_trace(tgt - off, jal_word(rd, off),
                       ($urandom_range(0, 4) != 0) ? tgt : $urandom);
        end else if (r < 54) begin
            push_trace(pick_target(),
                       jalr_word(rd, 5'($urandom), F3_JALR, 12'($urandom)), tgt);
        end else if (r < 82) begin
            push_trace(pick_target(),
                       jalr_word(REG_ZERO, REG_RA, F3_JALR, 12'($urandom)), tgt);
        end else begin
            case ($urandom_range(0, 4))
                0: push_trace(tgt - off, $urandom, tgt);
                1: begin
                    rd = 5'($urandom_range(0, 31));
                    if (rd == REG_RA || rd == REG_T0)
                        rd = REG_ZERO;
                    push_trace(tgt - off, jal_word(rd, off), tgt);
                end
                2: push_trace(tgt, jalr_word(REG_RA, REG_RA, 3'($urandom_range(1, 7)),
                                             12'($urandom)), tgt);
                3: push_trace(tgt, jalr_word(REG_ZERO, 5'($urandom_range(2, 31)), F3_JALR,
                                             12'($urandom)), tgt);
                default: push_trace(tgt, jalr_word(5'($urandom_range(6, 31)), REG_RA,
                                                   F3_JALR, 12'($urandom)), tgt);
            endcase
        end
    endtask

    task automatic set_count(input logic [COUNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    task automatic set_idle(input idle_mode_e m);
        send_idle_pct = (m == IDLE_SEND) ? 67 : (m == IDLE_BOTH) ? 10 : 0;
        recv_stall_pct = (m == IDLE_RECV) ? 67 : (m == IDLE_BOTH) ? 10 : 0;
    endtask

    // every beat taken and every event seen, then let the back end settle
    task automatic wait_idle();
        while (beats_taken != beats_queued || expected_events.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    int unsigned phase_cnt[N_PHASES]   = '{1, 8, 3, 64, 127, 16, 65, 5, 0, 2};
    int unsigned phase_items[N_PHASES] = '{80, 90, 90, 40, 30, 90, 30, 90, 20, 40};
    idle_mode_e  phase_idle[N_PHASES]  = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                           IDLE_NONE, IDLE_BOTH, IDLE_RECV, IDLE_SEND,
                                           IDLE_NONE, IDLE_NONE};

    initial begin : run_test
        int unsigned k;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tracing is off until the count is written
        push_trace(32'h100, jal_word(REG_RA, 32'h40), 32'h140);
        push_trace(32'h140, jalr_word(REG_ZERO, REG_RA, F3_JALR, 12'h0), 32'h104);
        push_write(6'd0, 32'h0000_1000, 32'h100);
        push_write(6'd1, 32'h0000_2000, 32'h0);
        push_write(6'd2, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        push_write(6'd3, 32'h0000_1000, 32'h10);
        live_slots = 4;
        wait_idle();
        set_count(7'd4);
        push_trace(32'h1800, jal_word(REG_RA, 32'hFFFF_F800), 32'h1000);
        push_trace(32'h1000_0000, jal_word(REG_T0, 32'h000F_FFFE), 32'h100F_FFFE);
        push_trace(32'h1000, jal_word(REG_RA, 32'hFFF0_0000), 32'hFFF0_1000);
        push_trace(32'h3000, jalr_word(REG_RA, REG_RA, F3_JALR, 12'h7ff), 32'h2003);
        push_trace(32'h3004, jalr_word(REG_T0, REG_T0, F3_JALR, 12'h0), 32'h2004);
        push_trace(32'h3008, jalr_word(REG_RA, REG_SP, F3_JALR, 12'h800), 32'hFFFF_FFFF);
        push_trace(32'h300c, NOP_WORD, 32'h3010);
        push_trace(32'h3010, jal_word(REG_ZERO, 32'h20), 32'h3030);
        push_trace(32'h3030, jalr_word(REG_RA, REG_RA, F3_NONZERO, 12'h0), 32'h1000);
        push_trace(32'h3034, jalr_word(REG_ZERO, REG_T0, F3_JALR, 12'h0), 32'h1000);
        push_trace(32'h3038, jalr_word(REG_ZERO, REG_RA, F3_JALR, 12'h0), 32'h10FF);
        push_write(6'd3, 32'h0000_1000, 32'h10);
        push_trace(32'h303c, jalr_word(REG_ZERO, REG_RA, F3_JALR, 12'hfff), 32'h1004);
        push_trace(32'h3040, jalr_word(REG_ZERO, REG_RA, F3_JALR, 12'h0), 32'h1008);
        push_trace(32'h3044, jalr_word(REG_RA, REG_RA, F3_JALR, 12'h0), 32'h1100);
        push_trace(32'h3048, jalr_word(REG_ZERO, REG_RA, F3_JALR, 12'h0), 32'hFFFF_FFEF);
        push_trace(32'hFFFF_FFFC, jal_word(REG_T0, 32'h8), 32'h4);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            k = (phase_cnt[p] > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : phase_cnt[p];
            load_symbols((k == 0) ? 2 : k);
            wait_idle();
            set_count(COUNT_W'(phase_cnt[p]));
            set_idle(phase_idle[p]);
            // long receiver hold-off while the sender keeps offering
            if (p == 0)
                hold_req = 1'b1;
            for (int i = 0; i < phase_items[p]; i++)
                push_random_beat();
            wait_idle();
        end

        // long unbroken call chain, then unwind a little
        push_write(6'd0, 32'h0, 32'hFFFF_FFFF);
        wait_idle();
        set_count(7'd1);
        set_idle(IDLE_BOTH);
        for (int i = 0; i < CHAIN_CALLS; i++)
            push_trace($urandom, jal_word(REG_RA, {{11{1'b0}}, 20'($urandom), 1'b0}),
                       $urandom);
        for (int i = 0; i < 4; i++)
            push_trace($urandom, jalr_word(REG_ZERO, REG_RA, F3_JALR, 12'($urandom)),
                       $urandom);
        wait_idle();

        $display("summary: %0d beats, %0d events (%0d calls, %0d returns, %0d symbol hits)",
                 beats_taken, n_events, n_calls, n_rets, n_hits);
        $display("summary: %0d count settings, peak depth %0d, %0d cycles input held off",
                 cfg_writes, peak_depth, held_off);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rcrt_pkg.sv
rtl/core/rcrt_front.sv
rtl/core/rcrt_queue.sv
rtl/core/rcrt_back.sv
rtl/core/riscv_call_return_tracer.sv
sim/tb_riscv_call_return_tracer.sv
